// ----- src/lsms_pkg.sv -----
`timescale 1ns / 1ps

package lsms_pkg;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_CW   = 2'd1;
  localparam logic [1:0] DRV_CCW  = 2'd2;

  localparam logic [1:0] RSP_NONE = 2'd0;
  localparam logic [1:0] RSP_OK   = 2'd1;
  localparam logic [1:0] RSP_ERR  = 2'd2;
  localparam logic [1:0] RSP_ID   = 2'd3;

  localparam logic [4:0] C_ECS    = 5'd0;
  localparam logic [4:0] C_LAM    = 5'd1;
  localparam logic [4:0] C_LAS    = 5'd2;
  localparam logic [4:0] C_SSECW  = 5'd3;
  localparam logic [4:0] C_SSECCW = 5'd4;
  localparam logic [4:0] C_SSE    = 5'd5;
  localparam logic [4:0] C_SSFCW  = 5'd6;
  localparam logic [4:0] C_SSFCCW = 5'd7;
  localparam logic [4:0] C_SSF    = 5'd8;
  localparam logic [4:0] C_UPT    = 5'd9;
  localparam logic [4:0] C_LPB    = 5'd10;
  localparam logic [4:0] C_WPP    = 5'd11;
  localparam logic [4:0] C_TES1SP = 5'd12;
  localparam logic [4:0] C_TESCP  = 5'd13;
  localparam logic [4:0] C_WPC    = 5'd14;
  localparam logic [4:0] C_TWSCP  = 5'd15;
  localparam logic [4:0] C_TSPPE  = 5'd16;
  localparam logic [4:0] C_PUSHBR = 5'd17;
  localparam logic [4:0] C_PULLBR = 5'd18;

  localparam int SW_D1 = 0;
  localparam int SW_D2 = 1;
  localparam int SW_E1 = 2;
  localparam int SW_E2 = 3;
  localparam int SW_E3 = 4;
  localparam int SW_E4 = 5;
  localparam int SW_F1 = 6;
  localparam int SW_F3 = 8;
  localparam int SW_F4 = 9;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] command_code;
    logic [9:0] switch_levels;
  } item_t;

  typedef struct packed {
    logic [1:0] drive_d;
    logic [1:0] drive_e;
    logic [1:0] drive_f;
    logic [1:0] drive_t;
    logic [1:0] response;
    logic       busy_res;
  } result_t;

endpackage

// ----- src/limit_switch_motor_sequencer.sv -----
`timescale 1ns / 1ps
// Channel   Valid         Stall         Payload
// item      item_valid    item_stall    item   (kind, command_code, switch_levels)
// result    result_valid  result_stall  result (drives, response, busy_res)
//
// One result per item, via the input register and then the result register.
// One item per cycle unless stalled; the sequencer state updates in the same
// edge that loads the result register, so the next item sees it.
// rst (synchronous) idles the sequencer and resets its drive state to stop.
// A stalled result holds the input register, which then stalls item.

module limit_switch_motor_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  lsms_pkg::item_t      item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output lsms_pkg::result_t    result
);
  import lsms_pkg::*;

  logic    held_valid;
  item_t   held;
  logic    take;
  result_t res_next;

  assign take = held_valid && !(result_valid && result_stall);

  lsms_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .held_valid (held_valid),
    .held       (held),
    .take       (take)
  );

  lsms_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (take),
    .cur      (held),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= res_next;
    end
  end

endmodule

// ----- src/lsms_in_stage.sv -----
`timescale 1ns / 1ps

module lsms_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  lsms_pkg::item_t      item,
  output logic                 held_valid,
  output lsms_pkg::item_t      held,
  input  logic                 take
);
  import lsms_pkg::*;

  logic load;

  assign load       = item_valid && !item_stall;
  assign item_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end
  end

endmodule

// ----- src/lsms_seq.sv -----
`timescale 1ns / 1ps

module lsms_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  lsms_pkg::item_t      cur,
  output lsms_pkg::result_t    res_next
);
  import lsms_pkg::*;

  logic [4:0] active_command, active_command_next;
  logic       phase_bit, phase_bit_next;
  logic       running, running_next;
  logic [1:0] drv_d, drv_e, drv_f, drv_t;
  logic [1:0] drv_d_next, drv_e_next, drv_f_next, drv_t_next;
  logic [1:0] rsp;
  logic [9:0] lo;

  assign lo = ~cur.switch_levels;

  always_comb begin
    active_command_next = active_command;
    phase_bit_next      = phase_bit;
    running_next        = running;
    drv_d_next          = drv_d;
    drv_e_next          = drv_e;
    drv_f_next          = drv_f;
    drv_t_next          = drv_t;
    rsp                 = RSP_NONE;
    case (cur.kind)
      KIND_START: begin
        if (running) begin
          rsp = RSP_ERR;
        end else begin
          active_command_next = cur.command_code;
          rsp = RSP_OK;
          case (cur.command_code)
            C_ECS:    rsp = RSP_ID;
            C_LAM:    rsp = RSP_OK;
            C_LAS:    rsp = RSP_OK;
            C_SSECW:  drv_e_next = DRV_CCW;
            C_SSECCW: drv_e_next = DRV_CW;
            C_SSE:    drv_e_next = DRV_STOP;
            C_SSFCW:  drv_f_next = DRV_CCW;
            C_SSFCCW: drv_f_next = DRV_CW;
            C_SSF:    drv_f_next = DRV_STOP;
            C_PUSHBR: drv_t_next = DRV_CCW;
            C_PULLBR: drv_t_next = DRV_CW;
            C_UPT: begin
              if (!lo[SW_D1]) begin
                drv_d_next = DRV_CCW; running_next = 1'b1; rsp = RSP_NONE;
              end
            end
            C_LPB: begin
              if (!lo[SW_D2]) begin
                drv_d_next = DRV_CW; running_next = 1'b1; rsp = RSP_NONE;
              end
            end
            C_WPP: begin
              if (!lo[SW_E1]) begin
                running_next = 1'b1; rsp = RSP_NONE;
              end
            end
            C_TES1SP: begin
              phase_bit_next = 1'b0; drv_e_next = DRV_CCW;
              running_next = 1'b1; rsp = RSP_NONE;
            end
            C_TESCP: begin
              phase_bit_next = 1'b0; drv_e_next = DRV_CCW; drv_f_next = DRV_CCW;
              running_next = 1'b1; rsp = RSP_NONE;
            end
            C_WPC: begin
              phase_bit_next = !lo[SW_F1];
              running_next = 1'b1; rsp = RSP_NONE;
            end
            C_TWSCP: begin
              if (!(lo[SW_E3] && lo[SW_F3])) begin
                drv_e_next = DRV_CW; drv_f_next = DRV_CW;
                running_next = 1'b1; rsp = RSP_NONE;
              end
            end
            C_TSPPE: begin
              if (!(lo[SW_E4] && lo[SW_F4])) begin
                if (!lo[SW_E4]) drv_e_next = DRV_CW;
                if (!lo[SW_F4]) drv_f_next = DRV_CCW;
                running_next = 1'b1; rsp = RSP_NONE;
              end
            end
            default: rsp = RSP_ERR;
          endcase
        end
      end
      KIND_TICK: begin
        if (running) begin
          case (active_command)
            C_TES1SP: begin
              if (!phase_bit) begin
                if (lo[SW_E2]) phase_bit_next = 1'b1;
              end else if (!lo[SW_E2]) begin
                drv_e_next = DRV_STOP; running_next = 1'b0; rsp = RSP_OK;
              end
            end
            C_TESCP: begin
              if (!phase_bit) begin
                if (lo[SW_F4]) phase_bit_next = 1'b1;
              end else if (!lo[SW_F4]) begin
                drv_e_next = DRV_STOP; drv_f_next = DRV_STOP;
                active_command_next = C_UPT; drv_d_next = DRV_CCW;
              end
            end
            C_UPT: begin
              if (lo[SW_D1]) begin
                drv_d_next = DRV_STOP; running_next = 1'b0; rsp = RSP_OK;
              end
            end
            C_LPB: begin
              if (lo[SW_D2]) begin
                drv_d_next = DRV_STOP; running_next = 1'b0; rsp = RSP_OK;
              end
            end
            C_WPP: begin
              if (lo[SW_E1]) begin
                running_next = 1'b0; rsp = RSP_OK;
              end
            end
            C_WPC: begin
              if (!phase_bit) begin
                if (!lo[SW_F1]) phase_bit_next = 1'b1;
              end else if (lo[SW_F1]) begin
                running_next = 1'b0; rsp = RSP_OK;
              end
            end
            C_TWSCP: begin
              if (lo[SW_E3] && lo[SW_F3]) begin
                drv_e_next = DRV_STOP; drv_f_next = DRV_STOP;
                running_next = 1'b0; rsp = RSP_OK;
              end
            end
            C_TSPPE: begin
              if (lo[SW_E4]) drv_e_next = DRV_STOP;
              if (lo[SW_F4]) drv_f_next = DRV_STOP;
              if (lo[SW_E4] && lo[SW_F4]) begin
                running_next = 1'b0; rsp = RSP_OK;
              end
            end
            default: begin
              running_next = 1'b0; rsp = RSP_ERR;
            end
          endcase
        end
      end
      KIND_CANCEL: begin
        if (!running) begin
          rsp = RSP_ERR;
        end else begin
          running_next = 1'b0;
          rsp = RSP_OK;
          case (active_command)
            C_TES1SP: drv_e_next = DRV_STOP;
            C_TESCP, C_TWSCP, C_TSPPE: begin
              drv_e_next = DRV_STOP; drv_f_next = DRV_STOP;
            end
            C_UPT, C_LPB: drv_d_next = DRV_STOP;
            C_WPP, C_WPC: rsp = RSP_OK;
            default: rsp = RSP_ERR;
          endcase
        end
      end
      default: rsp = RSP_NONE;
    endcase
  end

  always_comb begin
    res_next.drive_d  = drv_d_next;
    res_next.drive_e  = drv_e_next;
    res_next.drive_f  = drv_f_next;
    res_next.drive_t  = drv_t_next;
    res_next.response = rsp;
    res_next.busy_res = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command <= C_ECS;
      phase_bit      <= 1'b0;
      running        <= 1'b0;
      drv_d          <= DRV_STOP;
      drv_e          <= DRV_STOP;
      drv_f          <= DRV_STOP;
      drv_t          <= DRV_STOP;
    end else if (step) begin
      active_command <= active_command_next;
      phase_bit      <= phase_bit_next;
      running        <= running_next;
      drv_d          <= drv_d_next;
      drv_e          <= drv_e_next;
      drv_f          <= drv_f_next;
      drv_t          <= drv_t_next;
    end
  end

endmodule

// ----- tb/sequencer_checker.sv -----
`timescale 1ns / 1ps

module sequencer_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  lsms_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  lsms_pkg::result_t result,
  output int                fail_count,
  output int                pending,
  output int                acted_count,
  output int                checked_count
);
  import lsms_pkg::*;

  logic [4:0] cur_cmd;
  logic       phase;
  logic       busy;
  logic [1:0] drv_d, drv_e, drv_f, drv_t;

  result_t expected_results[$];
  int      fail_n, acted_n, checked_n;

  function automatic logic sw_active(logic [9:0] lv, int idx);
    return !lv[idx];
  endfunction

  function automatic logic [1:0] start_command(logic [4:0] cmd, logic [9:0] lv);
    if (busy) return RSP_ERR;
    cur_cmd = cmd;
    case (cmd)
      C_ECS: return RSP_ID;
      C_LAM, C_LAS: return RSP_OK;
      C_SSECW: begin
        drv_e = DRV_CCW;
        return RSP_OK;
      end
      C_SSECCW: begin
        drv_e = DRV_CW;
        return RSP_OK;
      end
      C_SSE: begin
        drv_e = DRV_STOP;
        return RSP_OK;
      end
      C_SSFCW: begin
        drv_f = DRV_CCW;
        return RSP_OK;
      end
      C_SSFCCW: begin
        drv_f = DRV_CW;
        return RSP_OK;
      end
      C_SSF: begin
        drv_f = DRV_STOP;
        return RSP_OK;
      end
      C_PUSHBR: begin
        drv_t = DRV_CCW;
        return RSP_OK;
      end
      C_PULLBR: begin
        drv_t = DRV_CW;
        return RSP_OK;
      end
      C_UPT: begin
        if (sw_active(lv, SW_D1)) return RSP_OK;
        drv_d = DRV_CCW;
        busy  = 1'b1;
        return RSP_NONE;
      end
      C_LPB: begin
        if (sw_active(lv, SW_D2)) return RSP_OK;
        drv_d = DRV_CW;
        busy  = 1'b1;
        return RSP_NONE;
      end
      C_WPP: begin
        if (sw_active(lv, SW_E1)) return RSP_OK;
        busy = 1'b1;
        return RSP_NONE;
      end
      C_TES1SP: begin
        phase = 1'b0;
        drv_e = DRV_CCW;
        busy  = 1'b1;
        return RSP_NONE;
      end
      C_TESCP: begin
        phase = 1'b0;
        drv_e = DRV_CCW;
        drv_f = DRV_CCW;
        busy  = 1'b1;
        return RSP_NONE;
      end
      C_WPC: begin
        phase = !sw_active(lv, SW_F1);
        busy  = 1'b1;
        return RSP_NONE;
      end
      C_TWSCP: begin
        if (sw_active(lv, SW_E3) && sw_active(lv, SW_F3)) return RSP_OK;
        drv_e = DRV_CW;
        drv_f = DRV_CW;
        busy  = 1'b1;
        return RSP_NONE;
      end
      C_TSPPE: begin
        if (sw_active(lv, SW_E4) && sw_active(lv, SW_F4)) return RSP_OK;
        if (!sw_active(lv, SW_E4)) drv_e = DRV_CW;
        if (!sw_active(lv, SW_F4)) drv_f = DRV_CCW;
        busy = 1'b1;
        return RSP_NONE;
      end
      default: return RSP_ERR;
    endcase
  endfunction

  function automatic logic [1:0] tick_command(logic [9:0] lv);
    if (!busy) return RSP_NONE;
    case (cur_cmd)
      C_TES1SP: begin
        if (!phase) begin
          if (sw_active(lv, SW_E2)) phase = 1'b1;
        end else if (!sw_active(lv, SW_E2)) begin
          drv_e = DRV_STOP;
          busy  = 1'b0;
          return RSP_OK;
        end
        return RSP_NONE;
      end
      C_TESCP: begin
        if (!phase) begin
          if (sw_active(lv, SW_F4)) phase = 1'b1;
        end else if (!sw_active(lv, SW_F4)) begin
          // chain into the D return stroke
          drv_e   = DRV_STOP;
          drv_f   = DRV_STOP;
          cur_cmd = C_UPT;
          drv_d   = DRV_CCW;
        end
        return RSP_NONE;
      end
      C_UPT: begin
        if (sw_active(lv, SW_D1)) begin
          drv_d = DRV_STOP;
          busy  = 1'b0;
          return RSP_OK;
        end
        return RSP_NONE;
      end
      C_LPB: begin
        if (sw_active(lv, SW_D2)) begin
          drv_d = DRV_STOP;
          busy  = 1'b0;
          return RSP_OK;
        end
        return RSP_NONE;
      end
      C_WPP: begin
        if (sw_active(lv, SW_E1)) begin
          busy = 1'b0;
          return RSP_OK;
        end
        return RSP_NONE;
      end
      C_WPC: begin
        if (!phase) begin
          if (!sw_active(lv, SW_F1)) phase = 1'b1;
        end else if (sw_active(lv, SW_F1)) begin
          busy = 1'b0;
          return RSP_OK;
        end
        return RSP_NONE;
      end
      C_TWSCP: begin
        if (sw_active(lv, SW_E3) && sw_active(lv, SW_F3)) begin
          drv_e = DRV_STOP;
          drv_f = DRV_STOP;
          busy  = 1'b0;
          return RSP_OK;
        end
        return RSP_NONE;
      end
      C_TSPPE: begin
        if (sw_active(lv, SW_E4)) drv_e = DRV_STOP;
        if (sw_active(lv, SW_F4)) drv_f = DRV_STOP;
        if (sw_active(lv, SW_E4) && sw_active(lv, SW_F4)) begin
          busy = 1'b0;
          return RSP_OK;
        end
        return RSP_NONE;
      end
      default: begin
        busy = 1'b0;
        return RSP_ERR;
      end
    endcase
  endfunction

  function automatic logic [1:0] cancel_command();
    if (!busy) return RSP_ERR;
    case (cur_cmd)
      C_TES1SP: drv_e = DRV_STOP;
      C_TESCP, C_TWSCP, C_TSPPE: begin
        drv_e = DRV_STOP;
        drv_f = DRV_STOP;
      end
      C_UPT, C_LPB: drv_d = DRV_STOP;
      C_WPP, C_WPC: ;
      default: begin
        busy = 1'b0;
        return RSP_ERR;
      end
    endcase
    busy = 1'b0;
    return RSP_OK;
  endfunction

  function automatic result_t step_sequencer(item_t it);
    result_t r;
    logic [1:0] rsp;
    case (it.kind)
      KIND_START:  rsp = start_command(it.command_code, it.switch_levels);
      KIND_TICK:   rsp = tick_command(it.switch_levels);
      KIND_CANCEL: rsp = cancel_command();
      default:     rsp = RSP_NONE;
    endcase
    r.drive_d  = drv_d;
    r.drive_e  = drv_e;
    r.drive_f  = drv_f;
    r.drive_t  = drv_t;
    r.response = rsp;
    r.busy_res = busy;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cur_cmd = C_ECS;
      phase   = 1'b0;
      busy    = 1'b0;
      drv_d   = DRV_STOP;
      drv_e   = DRV_STOP;
      drv_f   = DRV_STOP;
      drv_t   = DRV_STOP;
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("%0t: unexpected result %h with nothing outstanding", $realtime, result);
        end else begin
          want = expected_results.pop_front();
          checked_n++;
          if (result.drive_d !== want.drive_d || result.drive_e !== want.drive_e ||
              result.drive_f !== want.drive_f || result.drive_t !== want.drive_t ||
              result.response !== want.response || result.busy_res !== want.busy_res) begin
            fail_n++;
            if (fail_n <= 10)
              $display("%0t: mismatch exp d=%0d e=%0d f=%0d t=%0d rsp=%0d busy=%0d",
                       $realtime, want.drive_d, want.drive_e, want.drive_f,
                       want.drive_t, want.response, want.busy_res,
                       " got d=%0d e=%0d f=%0d t=%0d rsp=%0d busy=%0d",
                       result.drive_d, result.drive_e, result.drive_f,
                       result.drive_t, result.response, result.busy_res);
          end
        end
      end
      if (item_valid && !item_stall) begin
        if (item.kind == KIND_START || item.kind == KIND_CANCEL ||
            (item.kind == KIND_TICK && busy))
          acted_n++;
        expected_results.push_back(step_sequencer(item));
      end
    end
    fail_count    <= fail_n;
    pending       <= expected_results.size();
    acted_count   <= acted_n;
    checked_count <= checked_n;
  end

endmodule

// ----- tb/tb_limit_switch_motor_sequencer.sv -----
`timescale 1ns / 1ps

module tb_limit_switch_motor_sequencer;
  import lsms_pkg::*;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int         LONG_HOLD    = 60;
  localparam int         CYCLE_LIMIT  = 200000;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  int fail_count, pending, acted_count, checked_count;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int sent_n = 0;
  int cycle_n = 0;
  logic hold_off = 1'b0;

  limit_switch_motor_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  sequencer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .fail_count    (fail_count),
    .pending       (pending),
    .acted_count   (acted_count),
    .checked_count (checked_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("limit_switch_motor_sequencer verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= hold_off || ($urandom_range(99) < rx_idle_pct);
  end

  // hold results back long enough for the block to back up into its input
  initial begin
    wait (sent_n >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic item_t make_item(logic [1:0] kind, logic [4:0] code, logic [9:0] lv);
    item_t it;
    it.kind          = kind;
    it.command_code  = code;
    it.switch_levels = lv;
    return it;
  endfunction

  function automatic logic [9:0] pick_levels();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 10'h000;
    if (r < 16) return 10'h3ff;
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic send_item(input item_t it);
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent_n++;
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // start a command, then feed it switch samples with some noise mixed in
  task automatic run_sequence();
    logic [4:0] code;
    int         n;
    int         r;
    if ($urandom_range(99) < 75) code = 5'($urandom_range(C_UPT, C_TSPPE));
    else code = 5'($urandom_range(0, 31));
    send_item(make_item(KIND_START, code, pick_levels()));
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 85)
        send_item(make_item(KIND_TICK, 5'($urandom_range(0, 31)), pick_levels()));
      else if (r < 93)
        send_item(make_item(KIND_CANCEL, 5'($urandom_range(0, 31)), pick_levels()));
      else if (r < 97)
        send_item(make_item(KIND_START, 5'($urandom_range(0, 31)), pick_levels()));
      else
        send_item(make_item(KIND_IGNORED, 5'($urandom_range(0, 31)), pick_levels()));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst         <= 1'b0;
    tx_idle_pct <= 11;
    rx_idle_pct <= 45;
    @(posedge clk);

    send_item(make_item(KIND_TICK, C_ECS, 10'h3ff));
    send_item(make_item(KIND_CANCEL, C_ECS, 10'h000));
    send_item(make_item(KIND_IGNORED, 5'h1f, 10'h3ff));
    for (int c = C_ECS; c <= C_SSF; c++)
      send_item(make_item(KIND_START, 5'(c), pick_levels()));
    send_item(make_item(KIND_START, C_PUSHBR, 10'h000));
    send_item(make_item(KIND_START, C_PULLBR, 10'h3ff));
    send_item(make_item(KIND_START, 5'h1f, 10'h3ff));
    send_item(make_item(KIND_START, 5'd19, 10'h000));
    send_item(make_item(KIND_START, C_UPT, 10'h3ff));
    send_item(make_item(KIND_START, C_LAS, 10'h3ff));
    send_item(make_item(KIND_TICK, C_ECS, 10'h3ff));
    send_item(make_item(KIND_TICK, C_ECS, 10'h3fe));
    send_item(make_item(KIND_START, C_TESCP, 10'h3ff));
    send_item(make_item(KIND_TICK, C_ECS, 10'h1ff));
    send_item(make_item(KIND_TICK, C_ECS, 10'h3ff));
    send_item(make_item(KIND_CANCEL, C_ECS, 10'h3ff));
    send_item(make_item(KIND_START, C_TSPPE, 10'h000));

    while (sent_n < 600) run_sequence();
    tx_idle_pct <= 45;
    rx_idle_pct <= 11;
    while (sent_n < 1150) run_sequence();
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    while (sent_n < 1700) run_sequence();
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d transactions, %0d acted on by the sequencer, %0d results compared,",
             sent_n, acted_count, checked_count);
    $display("over three idle mixes and one %0d-cycle result hold-off.", LONG_HOLD);
    if (fail_count == 0 && pending == 0) begin
      $display("limit_switch_motor_sequencer verification clean");
    end else begin
      $display("limit_switch_motor_sequencer verification failed");
    end
    $finish;
  end

endmodule
